[sv/ccl_pkg.sv]
// ----------------------------------------------------------------------------
// ccl_pkg
// shared types and constants of the command line parser
// ----------------------------------------------------------------------------
`default_nettype none
package ccl_pkg;
    localparam int unsigned MAX_LINE_LENGTH = 4095;
    localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [31:0] SAT_MAG = 32'h8000_0000;
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_SP = 8'd32;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ARMED = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [4:0] KW_ALL = 5'h1F;
    localparam int unsigned KW_WRAP = 0;

    typedef enum logic [2:0] {
        PH_START = 3'd0, PH_CMD = 3'd1, PH_CMD_WS = 3'd2, PH_GAP1 = 3'd3,
        PH_TOK1 = 3'd4, PH_GAP2 = 3'd5, PH_TOK2 = 3'd6, PH_REST = 3'd7
    } t_phase;

    // token sub-states
    localparam logic [2:0] TK_START = 3'd0;
    localparam logic [2:0] TK_SIGN = 3'd1;
    localparam logic [2:0] TK_ZERO = 3'd2;
    localparam logic [2:0] TK_DIGITS = 3'd3;

    typedef struct packed {
        logic [1:0] status;
    } t_result;

    function automatic logic [4:0] kw_char_match(input logic [7:0] lc, input logic [2:0] pos);
        logic [4:0] m;
        m = '0;
        case (pos)
            3'd0: m = {lc == "h", lc == "s", lc == "g", lc == "s", lc == "w"};
            3'd1: m = {lc == "e", lc == "e", lc == "e", lc == "c", lc == "r"};
            3'd2: m = {lc == "a", lc == "t", lc == "t", lc == "a", lc == "a"};
            3'd3: m = {lc == "d", 1'b0, 1'b0, lc == "n", lc == "p"};
            3'd4: m = {lc == "i", 4'b0};
            3'd5: m = {lc == "n", 4'b0};
            3'd6: m = {lc == "g", 4'b0};
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] kw_len_mask(input logic [2:0] n);
        logic [4:0] m;
        m = '0;
        case (n)
            3'd3: m = 5'b01100;
            3'd4: m = 5'b00011;
            3'd7: m = 5'b10000;
            default: m = '0;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

[sv/ccl_crc.sv]
// ----------------------------------------------------------------------------
// ccl_crc
// one byte of msb-first crc-16, eight steps unrolled
// ----------------------------------------------------------------------------
`default_nettype none
module ccl_crc (
    input  wire logic [15:0] i_crc,
    input  wire logic [15:0] i_poly,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int j = 0; j < 8; j++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ i_poly) : {c[14:0], 1'b0};
        end
        o_crc = c;
    end
endmodule
`default_nettype wire

[sv/ccl_token.sv]
// ----------------------------------------------------------------------------
// ccl_token
// numeric token accumulator, one digit a beat, saturating
// ----------------------------------------------------------------------------
`default_nettype none
module ccl_token (
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_hex,
    input  wire logic        i_fresh,
    input  wire logic [31:0] i_acc,
    input  wire logic        i_neg,
    input  wire logic        i_stop,
    input  wire logic [2:0]  i_sub,
    output logic      [31:0] o_acc,
    output logic             o_neg,
    output logic             o_stop,
    output logic      [2:0]  o_sub
);
    logic [31:0] acc;
    logic        neg, stop;
    logic [2:0]  sub;
    logic [4:0]  d;
    logic        is_d;
    logic [36:0] prod;

    always_comb begin
        acc  = i_fresh ? '0 : i_acc;
        neg  = i_fresh ? 1'b0 : i_neg;
        stop = i_fresh ? 1'b0 : i_stop;
        sub  = i_fresh ? ccl_pkg::TK_START : i_sub;
        is_d = 1'b1;
        d    = '0;
        if (i_byte >= "0" && i_byte <= "9") d = 5'(i_byte - "0");
        else if (i_hex && i_byte >= "a" && i_byte <= "f") d = 5'(i_byte - "a" + 8'd10);
        else if (i_hex && i_byte >= "A" && i_byte <= "F") d = 5'(i_byte - "A" + 8'd10);
        else is_d = 1'b0;
        prod = i_hex ? {1'b0, acc, 4'b0} + 37'(d)
                     : {2'b0, acc, 3'b0} + {4'b0, acc, 1'b0} + 37'(d);
        o_acc = acc; o_neg = neg; o_stop = stop; o_sub = sub;
        if (!stop) begin
            if (sub == ccl_pkg::TK_START && (i_byte == "+" || i_byte == "-")) begin
                o_neg = (i_byte == "-");
                o_sub = ccl_pkg::TK_SIGN;
            end else if (i_hex && sub == ccl_pkg::TK_ZERO && (i_byte == "x" || i_byte == "X")) begin
                o_sub = ccl_pkg::TK_DIGITS;
            end else if (!is_d) begin
                o_stop = 1'b1;
            end else begin
                o_sub = (i_hex && sub <= ccl_pkg::TK_SIGN && i_byte == "0")
                        ? ccl_pkg::TK_ZERO : ccl_pkg::TK_DIGITS;
                o_acc = (prod > 37'(ccl_pkg::SAT_MAG)) ? ccl_pkg::SAT_MAG : prod[31:0];
            end
        end
    end
endmodule
`default_nettype wire

[sv/crc_checked_command_line_parser_unit.sv]
// ----------------------------------------------------------------------------
// crc_checked_command_line_parser_unit
// splits a byte stream into lines, checks crc and length, classifies commands
// ----------------------------------------------------------------------------
// Bytes enter on the s_axis channel (tdata[7:0] = data_byte), one beat per
// cycle while s_axis_tready is high. A newline byte closes the line and yields
// one result beat on m_axis (tdata[1:0] = line_status); other bytes yield none.
// Each accepted byte updates the line state at the accepting edge (eight-step
// crc, keyword match, one digit accumulate), and a newline loads the output
// register, so a result appears in the cycle after its newline.
// Throughput is one byte per cycle while s_axis_tready is high. The output
// register holds one result; while it is full and not taken, s_axis_tready is
// low, otherwise a new byte is taken even in the cycle the result leaves.
// The polynomial is written on the cfg channel (cfg_tdata[15:0]), always
// ready; write it only while idle.
// Synchronous active-low reset restores the polynomial to 0x1021, clears the
// line state and the armed check, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module crc_checked_command_line_parser_unit #(
    parameter int unsigned MAX_LINE_LENGTH = ccl_pkg::MAX_LINE_LENGTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // [1:0] line_status, rest zero
    input  wire logic        cfg_tvalid,
    output logic             cfg_tready,
    input  wire logic [15:0] cfg_tdata       // [15:0] crc_poly
);
    localparam int unsigned LW = $clog2(MAX_LINE_LENGTH + 1);

    logic [15:0] r_poly, r_crc, n_crc_b;
    logic [LW-1:0] r_len;
    ccl_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_live, n_live;
    logic [2:0]  r_kc, n_kc;
    logic [31:0] r_acc, n_acc, r_v1, n_v1, r_v2, n_v2, r_exp_crc, r_exp_len;
    logic        r_neg, n_neg, r_stop, n_stop, r_armed;
    logic        r_ovalid;
    ccl_pkg::t_result r_res, n_res;

    logic [7:0]  b, lc;
    logic        ws, acc_take, is_nl;
    logic        t_hex, t_fresh, t_use;
    logic [31:0] t_acc, tokv;
    logic        t_neg, t_stop;
    logic [2:0]  t_sub;

    assign b = s_axis_tdata;
    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign acc_take = s_axis_tvalid && s_axis_tready;
    assign is_nl = (b == ccl_pkg::CH_NL);
    assign cfg_tready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {6'b0, r_res.status};
    assign ws = (b == ccl_pkg::CH_SP) || (b >= 8'd9 && b <= 8'd13);
    assign lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;

    ccl_crc u_crc (.i_crc(r_crc), .i_poly(r_poly), .i_byte(b), .o_crc(n_crc_b));

    ccl_token u_tok (
        .i_byte(b), .i_hex(t_hex), .i_fresh(t_fresh), .i_acc(r_acc), .i_neg(r_neg),
        .i_stop(r_stop), .i_sub(r_kc), .o_acc(t_acc), .o_neg(t_neg),
        .o_stop(t_stop), .o_sub(t_sub)
    );

    // value of the token held so far
    assign tokv = r_neg ? (32'd0 - r_acc)
                        : ((r_acc > ccl_pkg::SAT_POS) ? ccl_pkg::SAT_POS : r_acc);

    always_comb begin
        t_fresh = (r_phase == ccl_pkg::PH_GAP1 || r_phase == ccl_pkg::PH_GAP2);
        t_hex = r_live[ccl_pkg::KW_WRAP] &&
                (r_phase == ccl_pkg::PH_GAP1 || r_phase == ccl_pkg::PH_TOK1);
        t_use = 1'b0;
        n_phase = r_phase; n_live = r_live; n_kc = r_kc;
        n_v1 = r_v1; n_v2 = r_v2;
        case (r_phase)
            ccl_pkg::PH_START: if (!ws) begin
                n_live = r_live & ccl_pkg::kw_char_match(lc, r_kc);
                n_kc = r_kc + 3'd1;
                n_phase = ccl_pkg::PH_CMD;
            end
            ccl_pkg::PH_CMD: begin
                if (b == ccl_pkg::CH_SP) begin
                    n_live = r_live & ccl_pkg::kw_len_mask(r_kc);
                    n_kc = '0;
                    n_phase = ccl_pkg::PH_GAP1;
                end else if (ws) begin
                    n_phase = ccl_pkg::PH_CMD_WS;
                end else begin
                    n_live = r_live & ccl_pkg::kw_char_match(lc, r_kc);
                    if (r_kc != 3'd7) n_kc = r_kc + 3'd1;
                end
            end
            ccl_pkg::PH_CMD_WS: begin
                if (b == ccl_pkg::CH_SP) begin
                    n_live = '0; n_kc = '0; n_phase = ccl_pkg::PH_GAP1;
                end else if (!ws) begin
                    n_live = '0; n_phase = ccl_pkg::PH_CMD;
                end
            end
            ccl_pkg::PH_GAP1, ccl_pkg::PH_GAP2: if (!ws) begin
                t_use = 1'b1;
                n_phase = (r_phase == ccl_pkg::PH_GAP1) ? ccl_pkg::PH_TOK1 : ccl_pkg::PH_TOK2;
            end
            ccl_pkg::PH_TOK1: begin
                if (b == ccl_pkg::CH_SP) begin
                    n_v1 = tokv; n_phase = ccl_pkg::PH_GAP2;
                end else t_use = 1'b1;
            end
            ccl_pkg::PH_TOK2: begin
                if (b == ccl_pkg::CH_SP) begin
                    n_v2 = tokv; n_phase = ccl_pkg::PH_REST;
                end else t_use = 1'b1;
            end
            default: ;
        endcase
        n_acc = r_acc; n_neg = r_neg; n_stop = r_stop;
        if (t_use) begin
            n_acc = t_acc; n_neg = t_neg; n_stop = t_stop; n_kc = t_sub;
        end
    end

    // line end decision
    logic [4:0]  e_live;
    logic [31:0] e_v1, e_v2;
    logic        e_ok;
    always_comb begin
        e_live = r_live; e_v1 = r_v1; e_v2 = r_v2;
        if (r_phase == ccl_pkg::PH_CMD || r_phase == ccl_pkg::PH_CMD_WS)
            e_live = r_live & ccl_pkg::kw_len_mask(r_kc);
        else if (r_phase == ccl_pkg::PH_TOK1) e_v1 = tokv;
        else if (r_phase == ccl_pkg::PH_TOK2) e_v2 = tokv;
        e_ok = (32'(r_len) == r_exp_len) && ({16'd0, r_crc ^ ccl_pkg::CRC_INIT} == r_exp_crc);
        if (r_armed && !e_ok) n_res.status = ccl_pkg::ST_FAIL;
        else if (r_phase == ccl_pkg::PH_START || e_live == '0) n_res.status = ccl_pkg::ST_UNKNOWN;
        else if (e_live[ccl_pkg::KW_WRAP]) n_res.status = ccl_pkg::ST_ARMED;
        else n_res.status = ccl_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= ccl_pkg::CRC_POLY_RESET;
            r_armed <= 1'b0; r_exp_crc <= '0; r_exp_len <= '0;
            r_ovalid <= 1'b0;
            r_crc <= ccl_pkg::CRC_INIT; r_len <= '0; r_phase <= ccl_pkg::PH_START;
            r_live <= ccl_pkg::KW_ALL; r_kc <= '0; r_acc <= '0; r_neg <= 1'b0;
            r_stop <= 1'b0; r_v1 <= '0; r_v2 <= '0;
        end else begin
            if (cfg_tvalid) r_poly <= cfg_tdata;
            if (acc_take && is_nl) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (acc_take) begin
                if (is_nl) begin
                    r_res <= n_res;
                    if (n_res.status == ccl_pkg::ST_ARMED) begin
                        r_armed <= 1'b1; r_exp_crc <= e_v1; r_exp_len <= e_v2;
                    end else r_armed <= 1'b0;
                    r_crc <= ccl_pkg::CRC_INIT; r_len <= '0; r_phase <= ccl_pkg::PH_START;
                    r_live <= ccl_pkg::KW_ALL; r_kc <= '0; r_acc <= '0; r_neg <= 1'b0;
                    r_stop <= 1'b0; r_v1 <= '0; r_v2 <= '0;
                end else begin
                    r_crc <= n_crc_b;
                    if (32'(r_len) < 32'(MAX_LINE_LENGTH)) r_len <= r_len + LW'(1);
                    r_phase <= n_phase; r_live <= n_live; r_kc <= n_kc;
                    r_acc <= n_acc; r_neg <= n_neg; r_stop <= n_stop;
                    r_v1 <= n_v1; r_v2 <= n_v2;
                end
            end
        end
    end
endmodule
`default_nettype wire

[sv/ccl_checker.sv]
// ----------------------------------------------------------------------------
// ccl_checker
// port-level checks of the command line parser
// ----------------------------------------------------------------------------
`default_nettype none
module ccl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    // a newline beat gives a result in the next cycle
    a_nl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata == 8'd10 |=> m_axis_tvalid)
        else $error("newline beat without result");
    // a non-newline beat with no pending result gives none
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata != 8'd10 &&
        (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
        else $error("result without newline");
    // input open whenever output can drain
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled needlessly");
    // upper result bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0)
        else $error("padding bits set");
endmodule

bind crc_checked_command_line_parser_unit ccl_checker u_ccl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
